/* rtl/core/lvm_pkg.sv */
// Level meter bar graph: shared types, field widths and constants.
// No dependencies; imported by every module of the core.
package lvm_pkg;

  localparam int DB_W        = 16;
  localparam int DEFL_W      = 17;
  localparam int OUT_W       = 10;
  localparam int BAR_W       = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // output tdata field offsets
  localparam int OUT_NORMAL_LSB  = 0;
  localparam int OUT_WARN_LSB    = 10;
  localparam int OUT_OVER_LSB    = 20;
  localparam int OUT_PEAK_LSB    = 30;
  localparam int OUT_VISIBLE_BIT = 40;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_DB   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_DB   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WARN_DB    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BAR_LENGTH = 2'd3;

  localparam logic signed [DB_W-1:0] LOWER_DB_RST = -16'sd17920;
  localparam logic signed [DB_W-1:0] UPPER_DB_RST = 16'sd1536;
  localparam logic signed [DB_W-1:0] WARN_DB_RST  = -16'sd1536;
  localparam logic [BAR_W-1:0]       BAR_LEN_RST  = 10'd98;

  // 100 percent deflection in 1/256 percent
  localparam logic [DEFL_W-1:0] FULL_SCALE = 17'd25600;

  // IEC scale segment boundaries in 1/256 dB
  localparam logic signed [DB_W-1:0] SEG_70_DB = -16'sd17920;
  localparam logic signed [DB_W-1:0] SEG_60_DB = -16'sd15360;
  localparam logic signed [DB_W-1:0] SEG_50_DB = -16'sd12800;
  localparam logic signed [DB_W-1:0] SEG_40_DB = -16'sd10240;
  localparam logic signed [DB_W-1:0] SEG_30_DB = -16'sd7680;
  localparam logic signed [DB_W-1:0] SEG_20_DB = -16'sd5120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEFL,
    ST_SETUP,
    ST_RUN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_RUN
  } lane_mode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic len_bit;
  } lane_ctl_t;

endpackage

/* rtl/core/lvm_deflect.sv */
// Level meter bar graph: IEC seven-segment dB to deflection mapping.
// Combinational; depends on lvm_pkg.
module lvm_deflect (
  input  logic signed [lvm_pkg::DB_W-1:0] level_db,
  output logic [lvm_pkg::DEFL_W-1:0]      defl
);
  import lvm_pkg::*;

  logic [18:0] dx;
  logic [18:0] u1, u2, u3, u4, u5, u6;
  logic [18:0] m3, m4, m6;
  logic [18:0] res;

  always_comb begin
    dx  = {{3{level_db[DB_W-1]}}, level_db};
    u1  = dx + 19'd17920;
    u2  = dx + 19'd15360;
    u3  = dx + 19'd12800;
    u4  = dx + 19'd10240;
    u5  = dx + 19'd7680;
    u6  = dx + 19'd5120;
    m3  = u3 + (u3 << 1);
    m4  = u4 + (u4 << 1);
    m6  = u6 + (u6 << 2);
    priority if (level_db < SEG_70_DB) begin
      res = 19'd0;
    end else if (level_db < SEG_60_DB) begin
      res = u1 >> 2;
    end else if (level_db < SEG_50_DB) begin
      res = (u2 >> 1) + 19'd640;
    end else if (level_db < SEG_40_DB) begin
      res = (m3 >> 2) + 19'd1920;
    end else if (level_db < SEG_30_DB) begin
      res = (m4 >> 1) + 19'd3840;
    end else if (level_db < SEG_20_DB) begin
      res = (u5 << 1) + 19'd7680;
    end else begin
      res = (m6 >> 1) + 19'd12800;
    end
    defl = res[DEFL_W-1:0];
  end

endmodule

/* rtl/core/lvm_lane.sv */
// Level meter bar graph: bit-serial scaler, floor(len * num / range),
// one bit of len per cycle, MSB first, quotient digit 0..2.
// Depends on lvm_pkg.
module lvm_lane #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lvm_pkg::lane_ctl_t         ctl,
  input  lvm_pkg::lane_mode_t        mode,
  input  logic [lvm_pkg::DEFL_W-1:0] num,
  input  logic [lvm_pkg::DEFL_W-1:0] range,
  input  logic [LENGTH_BITS-1:0]     len,
  output logic [LENGTH_BITS-1:0]     q
);
  import lvm_pkg::*;

  logic                   run_r;
  logic [DEFL_W-1:0]      num_r;
  logic [DEFL_W-1:0]      rem_r;
  logic [LENGTH_BITS-1:0] q_r;

  logic [DEFL_W+1:0]      trial;
  logic [DEFL_W+1:0]      rng1;
  logic [DEFL_W+1:0]      rng2;
  logic [DEFL_W+1:0]      rem_full;
  logic [1:0]             digit;
  logic [DEFL_W-1:0]      rem_nxt;
  logic [LENGTH_BITS-1:0] q_nxt;

  always_comb begin
    trial = {1'b0, rem_r, 1'b0} + (ctl.len_bit ? {2'b00, num_r} : '0);
    rng1  = {2'b00, range};
    rng2  = {1'b0, range, 1'b0};
    priority if (trial >= rng2) begin
      digit    = 2'd2;
      rem_full = trial - rng2;
    end else if (trial >= rng1) begin
      digit    = 2'd1;
      rem_full = trial - rng1;
    end else begin
      digit    = 2'd0;
      rem_full = trial;
    end
    rem_nxt = rem_full[DEFL_W-1:0];
    q_nxt   = (q_r << 1) + LENGTH_BITS'(digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (ctl.load) begin
      run_r <= (mode == MODE_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num_r <= num;
      rem_r <= '0;
      q_r   <= (mode == MODE_FULL) ? len : '0;
    end else if (ctl.step && run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/level_meter_bargraph_core.sv */
// A level item passes through ST_DEFL, ST_SETUP, ST_RUN and ST_OUT to out_tvalid;
// the core takes no new item until the result is loaded into the output register.
// ST_RUN is paced by the bit-serial scaler lanes that take one bit of the bar length
// per cycle. A peak-reset item is taken only in idle and gives no output.
// Reset (rst_n low, synchronous): peak hold cleared, registers to defaults,
// output empty. Depends on lvm_pkg, lvm_deflect and lvm_lane.
module level_meter_bargraph_core #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [lvm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [lvm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lvm_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] level_db
  input  logic                                in_tuser,   // [0] operation
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] normal_end, [19:10] warning_end, [29:20] over_end,
  // [39:30] peak_position, [40] peak_visible, [47:41] zero
  output logic [lvm_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import lvm_pkg::*;

  localparam int CNT_W   = $clog2(LENGTH_BITS);
  localparam int N_LANES = 4;

  // config registers
  logic signed [DB_W-1:0] lower_db_r, upper_db_r, warn_db_r;
  logic [BAR_W-1:0]       bar_length_r;

  state_t                 state_r, state_nxt;
  logic signed [DB_W-1:0] lvl_r;
  logic [DEFL_W-1:0]      lo_r, hi_r, v_r, w_r;
  logic [DEFL_W-1:0]      peak_r, peak_nxt;
  logic [DEFL_W-1:0]      range_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   pv_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                   in_acc;
  logic                   out_load;
  logic signed [DB_W-1:0] lvl_raise, lvl_clamp;
  logic [DEFL_W-1:0]      lo_d, hi_d, v_d, w_d;
  logic                   range_ok;
  logic [LENGTH_BITS+BAR_W-1:0] len_ext;
  lane_ctl_t              lane_ctl;
  logic [DEFL_W-1:0]      lane_x   [N_LANES];
  lane_mode_t             lane_mode[N_LANES];
  logic [DEFL_W-1:0]      lane_num [N_LANES];
  logic [LENGTH_BITS-1:0] lane_q   [N_LANES];
  logic [OUT_W+LENGTH_BITS-1:0] q_ext [N_LANES];

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_db_r   <= LOWER_DB_RST;
      upper_db_r   <= UPPER_DB_RST;
      warn_db_r    <= WARN_DB_RST;
      bar_length_r <= BAR_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOWER_DB:   lower_db_r   <= cfg_wdata;
        CFG_UPPER_DB:   upper_db_r   <= cfg_wdata;
        CFG_WARN_DB:    warn_db_r    <= cfg_wdata;
        CFG_BAR_LENGTH: bar_length_r <= cfg_wdata[BAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // clamp: raise to lower, then lower to upper
  always_comb begin
    lvl_raise = ($signed(in_tdata) < lower_db_r) ? lower_db_r : $signed(in_tdata);
    lvl_clamp = (lvl_raise > upper_db_r) ? upper_db_r : lvl_raise;
  end

  lvm_deflect u_defl_lo (.level_db(lower_db_r), .defl(lo_d));
  lvm_deflect u_defl_hi (.level_db(upper_db_r), .defl(hi_d));
  lvm_deflect u_defl_v  (.level_db(lvl_r),      .defl(v_d));
  lvm_deflect u_defl_w  (.level_db(warn_db_r),  .defl(w_d));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && !in_tuser) state_nxt = ST_DEFL;
      ST_DEFL:  state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN:   if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready        = 1'b0;
    lane_ctl.load    = 1'b0;
    lane_ctl.step    = 1'b0;
    lane_ctl.len_bit = len_r[cnt_r];
    unique case (state_r)
      ST_IDLE:  in_tready     = 1'b1;
      ST_SETUP: lane_ctl.load = 1'b1;
      ST_RUN:   lane_ctl.step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // peak hold
  assign peak_nxt = (v_r > peak_r) ? ((v_r > hi_r) ? hi_r : v_r) : peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (in_acc && in_tuser) begin
      peak_r <= '0;
    end else if (state_r == ST_SETUP) begin
      peak_r <= peak_nxt;
    end
  end

  // lane operands
  assign range_ok = (hi_r > lo_r);
  assign len_ext  = {{LENGTH_BITS{1'b0}}, bar_length_r};

  always_comb begin
    lane_x[0] = (v_r < w_r) ? v_r : w_r;
    lane_x[1] = ((v_r < w_r) || (v_r <= FULL_SCALE)) ? v_r : FULL_SCALE;
    lane_x[2] = v_r;
    lane_x[3] = peak_nxt;
    for (int i = 0; i < N_LANES; i++) begin
      lane_num[i] = lane_x[i] - lo_r;
      if (!range_ok || (lane_x[i] <= lo_r)) begin
        lane_mode[i] = MODE_ZERO;
      end else if (lane_x[i] >= hi_r) begin
        lane_mode[i] = MODE_FULL;
      end else begin
        lane_mode[i] = MODE_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lvl_r <= lvl_clamp;
    end
    if (state_r == ST_DEFL) begin
      lo_r <= lo_d;
      hi_r <= hi_d;
      v_r  <= v_d;
      w_r  <= w_d;
    end
    if (state_r == ST_SETUP) begin
      range_r <= hi_r - lo_r;
      len_r   <= len_ext[LENGTH_BITS-1:0];
      cnt_r   <= CNT_W'(LENGTH_BITS - 1);
      pv_r    <= range_ok && (peak_nxt > lo_r);
    end else if (state_r == ST_RUN) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    lvm_lane #(.LENGTH_BITS(LENGTH_BITS)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .mode  (lane_mode[g]),
      .num   (lane_num[g]),
      .range (range_r),
      .len   (len_ext[LENGTH_BITS-1:0]),
      .q     (lane_q[g])
    );
    assign q_ext[g] = {{OUT_W{1'b0}}, lane_q[g]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {7'd0, pv_r,
                      q_ext[3][OUT_W-1:0], q_ext[2][OUT_W-1:0],
                      q_ext[1][OUT_W-1:0], q_ext[0][OUT_W-1:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/core/lvm_checker.sv */
// Level meter bar graph: port-level checks and their bind to the core.
// Depends on lvm_pkg and level_meter_bargraph_core.
module lvm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lvm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lvm_pkg::*;

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // peak reset produces no item
  a_reset_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !$rose(out_tvalid))
    else $error("peak reset produced an item");

  // a level item keeps the core busy
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("level item accepted back to back");

  // hidden peak sits at the origin
  a_peak_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_VISIBLE_BIT] |->
      out_tdata[OUT_PEAK_LSB+OUT_W-1:OUT_PEAK_LSB] == '0)
    else $error("invisible peak with nonzero position");

endmodule

bind level_meter_bargraph_core lvm_checker u_lvm_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench for level_meter_bargraph_core: streams level and peak-clear items,
// predicts the bar ends and peak marker in a scoreboard class and checks each result.
// Depends on lvm_pkg and the core RTL only.
module tb;
  import lvm_pkg::*;

  localparam bit OP_LEVEL      = 1'b0;
  localparam bit OP_PEAK_CLEAR = 1'b1;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int N_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct packed {
    logic [OUT_W-1:0] normal_end;
    logic [OUT_W-1:0] warning_end;
    logic [OUT_W-1:0] over_end;
    logic [OUT_W-1:0] peak_position;
    logic             peak_visible;
  } bars_t;

  class bargraph_scoreboard;
    logic signed [DB_W-1:0] lower_db, upper_db, warn_db;
    logic [BAR_W-1:0]       bar_len;
    int                     peak;
    int                     errors;
    bars_t                  bars_due [$];

    function new();
      lower_db = LOWER_DB_RST;
      upper_db = UPPER_DB_RST;
      warn_db  = WARN_DB_RST;
      bar_len  = BAR_LEN_RST;
      peak     = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOWER_DB:   lower_db = val;
        CFG_UPPER_DB:   upper_db = val;
        CFG_WARN_DB:    warn_db  = val;
        CFG_BAR_LENGTH: bar_len  = val[BAR_W-1:0];
        default: ;
      endcase
    endfunction

    // IEC 268-18 scale, 1/256 dB in, 1/256 percent out
    function int deflection(int d);
      if (d < -17920) return 0;
      if (d < -15360) return (d + 17920) / 4;
      if (d < -12800) return (d + 15360) / 2 + 640;
      if (d < -10240) return (d + 12800) * 3 / 4 + 1920;
      if (d < -7680)  return (d + 10240) * 3 / 2 + 3840;
      if (d < -5120)  return (d + 7680) * 2 + 7680;
      return (d + 5120) * 5 / 2 + 12800;
    endfunction

    function int bar_pixels(int x, int lo, int range);
      longint q;
      int     len;
      len = bar_len;
      if (x <= lo) return 0;
      q = longint'(x - lo) * len / range;
      return (q > len) ? len : int'(q);
    endfunction

    function void note_level(bit op, logic [DB_W-1:0] data);
      int    lvl, lo_db, hi_db, lo, hi, v, w, range;
      bars_t b;
      if (op == OP_PEAK_CLEAR) begin
        peak = 0;
        return;
      end
      lvl   = int'($signed(data));
      lo_db = int'(lower_db);
      hi_db = int'(upper_db);
      if (lvl < lo_db) lvl = lo_db;
      if (lvl > hi_db) lvl = hi_db;
      lo = deflection(lo_db);
      hi = deflection(hi_db);
      v  = deflection(lvl);
      w  = deflection(int'(warn_db));
      if (v > peak) peak = (v > hi) ? hi : v;
      range = hi - lo;
      b = '0;
      if (range > 0) begin
        if (v < w) begin
          b.normal_end  = OUT_W'(bar_pixels(v, lo, range));
          b.warning_end = b.normal_end;
          b.over_end    = b.normal_end;
        end else if (v <= int'(FULL_SCALE)) begin
          b.normal_end  = OUT_W'(bar_pixels(w, lo, range));
          b.warning_end = OUT_W'(bar_pixels(v, lo, range));
          b.over_end    = b.warning_end;
        end else begin
          b.normal_end  = OUT_W'(bar_pixels(w, lo, range));
          b.warning_end = OUT_W'(bar_pixels(int'(FULL_SCALE), lo, range));
          b.over_end    = OUT_W'(bar_pixels(v, lo, range));
        end
        b.peak_position = OUT_W'(bar_pixels(peak, lo, range));
        b.peak_visible  = (peak > lo);
      end
      bars_due.push_back(b);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_bars(logic [OUT_TDATA_W-1:0] data);
      bars_t want;
      if (bars_due.size() == 0) begin
        $error("result with no level pending: %h", data);
        errors++;
        return;
      end
      want = bars_due.pop_front();
      compare("normal_end", want.normal_end, data[OUT_NORMAL_LSB +: OUT_W]);
      compare("warning_end", want.warning_end, data[OUT_WARN_LSB +: OUT_W]);
      compare("over_end", want.over_end, data[OUT_OVER_LSB +: OUT_W]);
      compare("peak_position", want.peak_position, data[OUT_PEAK_LSB +: OUT_W]);
      compare("peak_visible", want.peak_visible, data[OUT_VISIBLE_BIT]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_LOWER_DB;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [15:0] level_db
  logic                   in_tuser = 1'b0;  // [0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [9:0] normal_end, [19:10] warning_end, [29:20] over_end,
  // [39:30] peak_position, [40] peak_visible
  logic [OUT_TDATA_W-1:0] out_tdata;

  bargraph_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int stall_left;
  int idle_cycles;

  int probe [20] = '{-32768, 32767, -17921, -17920, -17919, -15361, -15360, -12801,
                     -12800, -10241, -10240, -7681, -7680, -5121, -5120, -1537,
                     -1536, 0, 1537, 1536};

  int tab_lo  [10] = '{-17920, -32768, -17920, -2000, -3000, -30000, -17920, -10000,
                       -20000, -8000};
  int tab_hi  [10] = '{1536, 32767, -5120, -9000, -3000, -20000, 1536, 0, -3000, -7900};
  int tab_wn  [10] = '{-1536, 0, -7680, -5000, 1234, -25000, -1536, -20000, 5000, -7950};
  int tab_len [10] = '{98, 1023, 200, 64, 500, 300, 'hFC00, 777, 1, 1023};

  level_meter_bargraph_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_level(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_bars(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle) stall_left = idle_len();
      end
    end
  end

  function automatic logic [DB_W-1:0] pick_level();
    int r, a, b, v;
    int seg [6] = '{-17920, -15360, -12800, -10240, -7680, -5120};
    r = $urandom_range(0, 99);
    a = int'(sb.lower_db);
    b = int'(sb.upper_db);
    if (a > b) begin
      v = a;
      a = b;
      b = v;
    end
    if (r < 8) return DB_W'($urandom);
    if (r < 22) begin
      case ($urandom_range(0, 3))
        0:       v = int'(sb.lower_db) + int'($urandom_range(0, 2)) - 1;
        1:       v = int'(sb.upper_db) + int'($urandom_range(0, 2)) - 1;
        2:       v = int'(sb.warn_db) + int'($urandom_range(0, 2)) - 1;
        default: v = seg[$urandom_range(0, 5)] + int'($urandom_range(0, 2)) - 1;
      endcase
    end else begin
      v = int'($urandom_range(0, b - a + 1024)) + a - 512;
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[DB_W-1:0];
  endfunction

  task automatic load_regs(input int lo, input int hi, input int wn, input int len);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_LOWER_DB, CFG_UPPER_DB, CFG_WARN_DB, CFG_BAR_LENGTH};
    val = '{lo[15:0], hi[15:0], wn[15:0], len[15:0]};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input bit op, input logic [DB_W-1:0] lvl);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= lvl;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.bars_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int lo, hi, wn, len;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 10) begin
        lo  = tab_lo[p];
        hi  = tab_hi[p];
        wn  = tab_wn[p];
        len = tab_len[p];
      end else if (p < 12) begin
        lo  = int'($urandom_range(0, 20000)) - 20000;
        hi  = lo + int'($urandom_range(1, 8000));
        wn  = int'($urandom_range(0, 30000)) - 22000;
        len = $urandom_range(1, 1023);
      end else begin
        lo  = $urandom;
        hi  = $urandom;
        wn  = $urandom;
        len = $urandom;
      end
      load_regs(lo, hi, wn, len);
      no_idle = (p == 1 || p == 9);
      if (p == 0) begin
        foreach (probe[i]) send_item(OP_LEVEL, probe[i][15:0]);
        send_item(OP_PEAK_CLEAR, 16'h5A5A);
        send_item(OP_LEVEL, 16'hBA00);
        send_item(OP_PEAK_CLEAR, 16'hA5A5);
      end
      if (p == 1) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 6) send_item(OP_PEAK_CLEAR, DB_W'($urandom));
        else send_item(OP_LEVEL, pick_level());
      end
      // leave the peak at the top so a lower range next phase puts it above range
      send_item(OP_LEVEL, 16'h7FFF);
      drain();
    end
    if (sb.errors == 0 && sb.bars_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lvm_pkg.sv
rtl/core/lvm_deflect.sv
rtl/core/lvm_lane.sv
rtl/core/level_meter_bargraph_core.sv
rtl/core/lvm_checker.sv
tb/sv/tb.sv
